[hw/rtl/data_cache_direct_or_two_way_core_assert.svh]
// assertion macros used by the checker file of the data cache
// no dependencies; include by bare file name
`ifndef DATA_CACHE_DIRECT_OR_TWO_WAY_CORE_ASSERT_SVH
`define DATA_CACHE_DIRECT_OR_TWO_WAY_CORE_ASSERT_SVH

// clocked assertion, switched off while reset is high
`define DC_ASSERT_RST(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("data cache check failed");

// clocked assertion that also holds during reset
`define DC_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("data cache check failed");

`endif

[hw/rtl/dcache_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and codes of the data cache
// no dependencies
package dcache_pkg;

  parameter int unsigned STORE_WORDS_DEF = 1024;
  parameter int unsigned CACHE_WORDS     = 16;
  parameter int unsigned CACHE_AW        = $clog2(CACHE_WORDS);
  parameter int unsigned LINE_SLOTS      = 4;
  parameter int unsigned SLOT_W          = 2;
  parameter int unsigned TAG_W           = 6;
  parameter int unsigned CFG_IDX_W       = 1;
  parameter int unsigned CFG_DATA_W      = 10;
  parameter int unsigned BASE_W          = 10;
  parameter int unsigned INDEX_W         = 10;
  parameter int unsigned WORD_W          = 32;
  parameter logic [31:0] MISS_PENALTY    = 32'd50;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ASSOC_MODE = 1'b0,
    CFG_STORE_BASE = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FILL,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic fill_step;
    logic read;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_write;
    logic need_fill;
    logic fill_done;
    logic out_free;
  } status_t;

endpackage

[hw/rtl/dcache_ifs.sv]
`timescale 1ns / 1ps
// request and response channel interfaces of the data cache
// depends on dcache_pkg
interface dcache_req_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [31:0]                         byte_address;
  logic [dcache_pkg::INDEX_W-1:0]      store_index;
  logic [dcache_pkg::WORD_W-1:0]       store_word;

  modport source (output valid, operation, byte_address, store_index, store_word,
                  input ready);
  modport sink (input valid, operation, byte_address, store_index, store_word,
                output ready);
endinterface

interface dcache_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] load_data;
  logic        was_hit;
  logic        range_error;
  logic [31:0] penalty_total;
  logic [31:0] miss_total;
  logic [31:0] read_total;

  modport source (output valid, load_data, was_hit, range_error, penalty_total,
                  miss_total, read_total, input ready);
  modport sink (input valid, load_data, was_hit, range_error, penalty_total,
                miss_total, read_total, output ready);
endinterface

[hw/rtl/dcache_ram.sv]
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module dcache_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/dcache_ctrl.sv]
`timescale 1ns / 1ps
// sequencer of the data cache: lookup, line fill, word read, result hand-off
// depends on dcache_pkg
module dcache_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dcache_pkg::status_t status,
  output dcache_pkg::cmd_t    cmd
);

  dcache_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dcache_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      dcache_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = dcache_pkg::ST_LOOKUP;
        end
      end
      dcache_pkg::ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        if (status.is_write) begin
          state_next = dcache_pkg::ST_DONE;
        end else if (status.need_fill) begin
          state_next = dcache_pkg::ST_FILL;
        end else begin
          state_next = dcache_pkg::ST_READ;
        end
      end
      dcache_pkg::ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_done) begin
          state_next = dcache_pkg::ST_READ;
        end
      end
      dcache_pkg::ST_READ: begin
        cmd.read   = 1'b1;
        state_next = dcache_pkg::ST_DONE;
      end
      dcache_pkg::ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = dcache_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dcache_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/dcache_datapath.sv]
`timescale 1ns / 1ps
// datapath of the data cache: tags, lru, counters, config, both rams, output register
// depends on dcache_pkg, dcache_ifs and dcache_ram
module dcache_datapath #(
  parameter int unsigned STORE_WORDS = dcache_pkg::STORE_WORDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic [dcache_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dcache_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                              operation,
  input  logic [31:0]                       byte_address,
  input  logic [dcache_pkg::INDEX_W-1:0]    store_index,
  input  logic [dcache_pkg::WORD_W-1:0]     store_word,
  input  dcache_pkg::cmd_t                  cmd,
  output dcache_pkg::status_t               status,
  dcache_rsp_if.source                      rsp
);

  localparam int unsigned STORE_AW = $clog2(STORE_WORDS);
  localparam int unsigned TW       = dcache_pkg::TAG_W;
  localparam int unsigned SW       = dcache_pkg::SLOT_W;

  // configuration
  logic                          assoc_mode;
  logic [dcache_pkg::BASE_W-1:0] store_base;

  // captured item
  dcache_pkg::op_t                op_q;
  logic [31:0]                    addr_q;
  logic [dcache_pkg::INDEX_W-1:0] sidx_q;
  logic [dcache_pkg::WORD_W-1:0]  sword_q;

  // cache state
  logic [TW-1:0]                     tags [dcache_pkg::LINE_SLOTS];
  logic [dcache_pkg::LINE_SLOTS-1:0] valid;
  logic [1:0]                        recent;
  logic [31:0]                       penalty_count;
  logic [31:0]                       miss_count;
  logic [31:0]                       read_count;

  // lookup results
  logic                err_q;
  logic                hit_q;
  logic [SW-1:0]       slot_q;
  logic [STORE_AW-1:0] first_q;

  // fill sequencing
  logic [2:0]  fill_cnt;
  logic        wr_pend;
  logic [1:0]  wr_idx;

  // lookup logic
  logic                              is_load;
  logic [TW-1:0]                     tag_sel;
  logic [dcache_pkg::LINE_SLOTS-1:0] match;
  logic [31:0]                       end_word;
  logic [31:0]                       first_word;
  logic [31:0]                       sidx_ext;
  logic                              err;
  logic                              hit;
  logic                              set_sel;
  logic [SW-1:0]                     k0;
  logic [SW-1:0]                     k1;
  logic [SW-1:0]                     slot;
  logic                              need_fill;

  // ram ports
  logic                                backing_we;
  logic                                backing_re;
  logic [STORE_AW-1:0]                 backing_raddr;
  logic [dcache_pkg::WORD_W-1:0]       backing_rdata;
  logic [dcache_pkg::CACHE_AW-1:0]     cache_waddr;
  logic [dcache_pkg::CACHE_AW-1:0]     cache_raddr;
  logic [dcache_pkg::WORD_W-1:0]       cache_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      assoc_mode <= 1'b0;
      store_base <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        dcache_pkg::CFG_ASSOC_MODE: assoc_mode <= cfg_wdata[0];
        dcache_pkg::CFG_STORE_BASE: store_base <= cfg_wdata[dcache_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= dcache_pkg::op_t'(operation);
      addr_q  <= byte_address;
      sidx_q  <= store_index;
      sword_q <= store_word;
    end
  end

  always_comb begin
    is_load    = (op_q == dcache_pkg::OP_LOAD);
    tag_sel    = assoc_mode ? addr_q[10:5] : addr_q[11:6];
    for (int i = 0; i < dcache_pkg::LINE_SLOTS; i++) begin
      match[i] = valid[i] && (tags[i] == tag_sel);
    end
    // last word of the line must sit inside the store
    end_word   = 32'(store_base) + {2'b00, addr_q[31:4], 2'b11};
    first_word = 32'(store_base) + {2'b00, addr_q[31:4], 2'b00};
    err        = (end_word >= 32'(STORE_WORDS));
    sidx_ext   = 32'(sidx_q);
    set_sel    = addr_q[4];
    k0         = {set_sel, 1'b0};
    k1         = {set_sel, 1'b1};
    if (!assoc_mode) begin
      hit  = match[addr_q[5:4]];
      slot = addr_q[5:4];
    end else begin
      hit = match[k0] | match[k1];
      if (hit || err) begin
        slot = match[k1] ? k1 : k0;
      end else if (!valid[k0]) begin
        slot = k0;
      end else if (!valid[k1]) begin
        slot = k1;
      end else begin
        slot = recent[set_sel] ? k1 : k0;
      end
    end
    need_fill  = is_load && !err && !hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= '0;
      recent        <= '0;
      penalty_count <= '0;
      miss_count    <= '0;
      read_count    <= '0;
      for (int i = 0; i < dcache_pkg::LINE_SLOTS; i++) begin
        tags[i] <= '0;
      end
    end else if (cmd.lookup && is_load) begin
      read_count <= read_count + 32'd1;
      if (need_fill) begin
        penalty_count <= penalty_count + dcache_pkg::MISS_PENALTY;
        miss_count    <= miss_count + 32'd1;
        tags[slot]    <= tag_sel;
        valid[slot]   <= 1'b1;
      end
      // the way that is read becomes most recent
      if (assoc_mode) begin
        recent[set_sel] <= ~slot[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      err_q   <= is_load && err;
      hit_q   <= is_load && !err && hit;
      slot_q  <= slot;
      first_q <= first_word[STORE_AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt <= '0;
      wr_pend  <= 1'b0;
    end else begin
      wr_pend <= cmd.fill_step && !fill_cnt[2];
      if (cmd.lookup) begin
        fill_cnt <= '0;
      end else if (cmd.fill_step && !fill_cnt[2]) begin
        fill_cnt <= fill_cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_step) begin
      wr_idx <= fill_cnt[1:0];
    end
  end

  assign backing_we    = cmd.lookup && (op_q == dcache_pkg::OP_WRITE)
                         && (sidx_ext < 32'(STORE_WORDS));
  assign backing_re    = cmd.fill_step && !fill_cnt[2];
  assign backing_raddr = first_q + STORE_AW'(fill_cnt[1:0]);
  assign cache_waddr   = {slot_q, wr_idx};
  assign cache_raddr   = {slot_q, addr_q[3:2]};

  dcache_ram #(
    .WIDTH (dcache_pkg::WORD_W),
    .DEPTH (STORE_WORDS)
  ) u_backing_ram (
    .clk   (clk),
    .we    (backing_we),
    .waddr (sidx_ext[STORE_AW-1:0]),
    .wdata (sword_q),
    .re    (backing_re),
    .raddr (backing_raddr),
    .rdata (backing_rdata)
  );

  dcache_ram #(
    .WIDTH (dcache_pkg::WORD_W),
    .DEPTH (dcache_pkg::CACHE_WORDS)
  ) u_line_ram (
    .clk   (clk),
    .we    (wr_pend),
    .waddr (cache_waddr),
    .wdata (backing_rdata),
    .re    (cmd.read),
    .raddr (cache_raddr),
    .rdata (cache_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.load_data     <= is_load ? cache_rdata : '0;
      rsp.was_hit       <= hit_q;
      rsp.range_error   <= err_q;
      rsp.penalty_total <= penalty_count;
      rsp.miss_total    <= miss_count;
      rsp.read_total    <= read_count;
    end
  end

  assign status.is_write  = (op_q == dcache_pkg::OP_WRITE);
  assign status.need_fill = need_fill;
  assign status.fill_done = fill_cnt[2];
  assign status.out_free  = !rsp.valid || rsp.ready;

endmodule

[hw/rtl/data_cache_direct_or_two_way_core.sv]
`timescale 1ns / 1ps
// channel   dir  handshake      payload
// req       in   valid/ready    operation, byte_address, store_index, store_word
// rsp       out  valid/ready    load_data, was_hit, range_error, three totals
// cfg       in   cfg_write_en   cfg_index, cfg_wdata
//
// load hit or range error: lookup, line read, result register; write into
// the store: lookup, result register; load miss: lookup, four reads of the
// simple dual-port backing ram plus the write of the last word into the line,
// then line read, result register; no new item until the result is registered
// a stalled rsp holds only the final hand-off of the following item
// synchronous reset clears tags, valid and lru bits, totals and config
module data_cache_direct_or_two_way_core #(
  parameter int unsigned STORE_WORDS = dcache_pkg::STORE_WORDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic [dcache_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dcache_pkg::CFG_DATA_W-1:0] cfg_wdata,
  dcache_req_if.sink                        req,
  dcache_rsp_if.source                      rsp
);

  dcache_pkg::cmd_t    cmd;
  dcache_pkg::status_t status;
  logic                in_ready;

  assign req.ready = in_ready;

  dcache_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dcache_datapath #(
    .STORE_WORDS (STORE_WORDS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .operation    (req.operation),
    .byte_address (req.byte_address),
    .store_index  (req.store_index),
    .store_word   (req.store_word),
    .cmd          (cmd),
    .status       (status),
    .rsp          (rsp)
  );

endmodule

[hw/rtl/dcache_checker.sv]
`timescale 1ns / 1ps
// port-level checks of the data cache, bound to the top level
// depends on data_cache_direct_or_two_way_core_assert.svh
`include "data_cache_direct_or_two_way_core_assert.svh"

module dcache_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_load_data,
  input logic [31:0] rsp_penalty_total,
  input logic [31:0] rsp_miss_total,
  input logic [31:0] rsp_read_total
);

  // a result waits until it is taken
  `DC_ASSERT_RST(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid)

  // a stalled result keeps its load data and read total
  `DC_ASSERT_RST(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready |=> $stable(rsp_load_data) && $stable(rsp_read_total))

  // no result can appear in the cycle right after a request transfer
  `DC_ASSERT_RST(a_min_latency, clk, rst, req_valid && req_ready |=> !$rose(rsp_valid))

  // every fill costs the same penalty
  `DC_ASSERT_ALWAYS(a_penalty_sum, clk, rsp_valid |-> rsp_penalty_total == 32'(rsp_miss_total * 32'd50))

endmodule

bind data_cache_direct_or_two_way_core dcache_checker u_dcache_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_load_data     (rsp.load_data),
  .rsp_penalty_total (rsp.penalty_total),
  .rsp_miss_total    (rsp.miss_total),
  .rsp_read_total    (rsp.read_total)
);
